// File: rtl/gkm_pkg.sv
// Shared command, item kind and register codes for the k-medoids engine.
package gkm_pkg;

    localparam int CMD_W  = 2;
    localparam int KIND_W = 2;
    localparam int REC_W  = 8;
    localparam int ATT_W  = 3;
    localparam int SLOT_W = 4;
    localparam int LBL_W  = 4;
    localparam int COST_W = 26;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int K_W = 5;
    localparam int N_W = 9;
    localparam int M_W = 4;

    typedef logic [CMD_W-1:0]  cmd_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [COST_W-1:0] cost_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cmd_t CMD_LOAD = 2'd0;
    localparam cmd_t CMD_RUN  = 2'd1;
    localparam cmd_t CMD_READ = 2'd2;

    localparam kind_t KIND_MEDOID = 2'd0;
    localparam kind_t KIND_LABEL  = 2'd1;
    localparam kind_t KIND_ERROR  = 2'd2;

    localparam cfg_idx_t CFG_CLUSTERS   = 2'd0;
    localparam cfg_idx_t CFG_RECORDS    = 2'd1;
    localparam cfg_idx_t CFG_ATTRIBUTES = 2'd2;

    localparam cost_t COST_MAX = 26'h3FF_FFFF;

endpackage

// File: rtl/greedy_k_medoids_clustering.sv
// Greedy k-medoids engine: point memory load, medoid search run, label read-back.
//
// Loads and label reads take one word each. After reset the label memory is swept to
// zero, all MAX_RECORDS entries, with no command taken. A run is exclusive. Each
// point-to-medoid distance streams the attributes through the point memories and then
// an integer square root unit that settles one result bit a cycle, for S result bits,
// S = ceil(min(2*VALUE_BITS + clog2(MAX_ATTRIBUTES+1), 64) / 2) (S = 18 by default).
// A run evaluates k*n*n*k distances for the search and n*k for labeling, then sends
// k medoid report words, the last one marked.
module greedy_k_medoids_clustering #(
    parameter int MAX_RECORDS    = 256,
    parameter int MAX_ATTRIBUTES = 8,
    parameter int MAX_CLUSTERS   = 16,
    parameter int VALUE_BITS     = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_en,
    input  logic [gkm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gkm_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [gkm_pkg::CMD_W-1:0]      command,
    input  logic [VALUE_BITS-1:0]          value,
    input  logic [gkm_pkg::REC_W-1:0]      record_index,
    input  logic [gkm_pkg::ATT_W-1:0]      attribute_index,

    output logic                           res_valid,
    input  logic                           res_stall,
    output logic [gkm_pkg::KIND_W-1:0]     item_kind,
    output logic [gkm_pkg::SLOT_W-1:0]     slot,
    output logic [gkm_pkg::REC_W-1:0]      chosen_record,
    output logic [gkm_pkg::LBL_W-1:0]      cluster_label,
    output logic [gkm_pkg::COST_W-1:0]     total_cost,
    output logic                           last
);

    localparam int VB    = VALUE_BITS;
    localparam int RB    = $clog2(MAX_RECORDS);
    localparam int CB    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int AIW   = $clog2(MAX_ATTRIBUTES + 1);
    localparam int PDEP  = MAX_RECORDS * MAX_ATTRIBUTES;
    localparam int PAW   = $clog2(PDEP);
    localparam int SW    = 2 * VB + AIW;
    localparam int SQW   = (SW > 64) ? 64 : SW;
    localparam int NSTEP = (SQW + 1) / 2;
    localparam int RW    = NSTEP;
    localparam int XW    = SQW + 1;
    localparam int SB    = $clog2(NSTEP + 1);
    localparam logic [XW-1:0] BIT_INIT = XW'(1) << (2 * (NSTEP - 1));

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RDWAIT = 4'd2;
    localparam logic [3:0] S_QSTART = 4'd3;
    localparam logic [3:0] S_RSTART = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DIST   = 4'd6;
    localparam logic [3:0] S_SQRT   = 4'd7;
    localparam logic [3:0] S_NEAR   = 4'd8;
    localparam logic [3:0] S_REND   = 4'd9;
    localparam logic [3:0] S_QEND   = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [gkm_pkg::K_W-1:0] k_reg, k_next;
    logic [gkm_pkg::N_W-1:0] n_reg, n_next;
    logic [gkm_pkg::M_W-1:0] m_reg, m_next;

    logic [CB-1:0]  p_reg, p_next;
    logic [RB-1:0]  q_reg, q_next;
    logic [RB-1:0]  r_reg, r_next;
    logic [CB-1:0]  s_reg, s_next;
    logic [AIW-1:0] i_reg, i_next;
    logic           lab_reg, lab_next;
    logic [RB-1:0]  clr_reg, clr_next;

    logic           v1_reg, v1_next, v2_reg, v2_next, v3_reg, v3_next;
    logic [VB-1:0]  diff_reg, diff_next;
    logic [2*VB-1:0] sq_reg, sq_next;
    logic [SW-1:0]  acc_reg, acc_next;

    logic [XW-1:0]  x_reg, x_next, res_reg, res_next, bit_reg, bit_next;
    logic [SB-1:0]  step_reg, step_next;

    logic [RW-1:0]  best_reg, best_next;
    logic [CB-1:0]  bslot_reg, bslot_next;
    gkm_pkg::cost_t total_reg, total_next;
    gkm_pkg::cost_t bcost_reg, bcost_next;
    logic [RB-1:0]  brec_reg, brec_next;

    logic [RB-1:0]  medoid_reg [MAX_CLUSTERS];
    gkm_pkg::cost_t cost_reg [MAX_CLUSTERS];
    logic           seed;
    logic           med_we;
    logic [RB-1:0]  med_wdata;
    logic           cost_we;

    logic                          ov_reg, ov_next;
    gkm_pkg::kind_t                okind_reg, okind_next;
    logic [gkm_pkg::SLOT_W-1:0]    oslot_reg, oslot_next;
    logic [gkm_pkg::REC_W-1:0]     orec_reg, orec_next;
    logic [gkm_pkg::LBL_W-1:0]     olbl_reg, olbl_next;
    gkm_pkg::cost_t                ocost_reg, ocost_next;
    logic                          olast_reg, olast_next;
    logic [gkm_pkg::REC_W-1:0]     rdrec_reg, rdrec_next;

    logic           pm_we;
    logic [PAW-1:0] pm_waddr, pa_raddr, pb_raddr;
    logic [VB-1:0]  pa_rdata, pb_rdata;
    logic           lb_we;
    logic [RB-1:0]  lb_waddr, lb_raddr;
    logic [gkm_pkg::LBL_W-1:0] lb_wdata, lb_rdata;

    logic           out_free, accept, bad_cfg;
    logic signed [VB:0] sa, sb;
    logic [XW-1:0]  sq_try;
    logic [RW-1:0]  dist_val;
    gkm_pkg::cost_t dcost;
    logic [gkm_pkg::COST_W:0] tsum;
    logic           upd;
    logic [RB-1:0]  nbrec;
    gkm_pkg::cost_t nbcost;

    gkm_ram #(.WIDTH(VB), .DEPTH(PDEP)) u_pts_a (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(value),
        .raddr(pa_raddr), .rdata(pa_rdata)
    );

    gkm_ram #(.WIDTH(VB), .DEPTH(PDEP)) u_pts_b (
        .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(value),
        .raddr(pb_raddr), .rdata(pb_rdata)
    );

    gkm_ram #(.WIDTH(gkm_pkg::LBL_W), .DEPTH(MAX_RECORDS)) u_labels (
        .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
        .raddr(lb_raddr), .rdata(lb_rdata)
    );

    assign out_free  = !ov_reg || !res_stall;
    assign cmd_stall = !(state_reg == S_IDLE && out_free);
    assign accept    = cmd_valid && !cmd_stall;

    assign bad_cfg = (k_reg == '0) || (32'(k_reg) > MAX_CLUSTERS)
                  || ({4'b0, k_reg} > n_reg) || (n_reg == '0)
                  || (32'(n_reg) > MAX_RECORDS) || (m_reg == '0)
                  || (32'(m_reg) > MAX_ATTRIBUTES);

    assign pm_waddr = PAW'(record_index) * PAW'(MAX_ATTRIBUTES) + PAW'(attribute_index);
    assign pa_raddr = PAW'(r_reg) * PAW'(MAX_ATTRIBUTES) + PAW'(i_reg);
    assign pb_raddr = PAW'(medoid_reg[s_reg]) * PAW'(MAX_ATTRIBUTES) + PAW'(i_reg);
    assign lb_raddr = RB'(record_index);

    assign sa       = {pa_rdata[VB-1], pa_rdata};
    assign sb       = {pb_rdata[VB-1], pb_rdata};
    assign sq_try   = res_reg + bit_reg;
    assign dist_val = res_reg[RW-1:0];
    assign dcost    = (64'(best_reg) > 64'(gkm_pkg::COST_MAX))
                    ? gkm_pkg::COST_MAX : gkm_pkg::COST_W'(best_reg);
    assign tsum     = {1'b0, total_reg} + {1'b0, dcost};
    assign upd      = (q_reg == '0) || (total_reg < bcost_reg);
    assign nbrec    = upd ? q_reg : brec_reg;
    assign nbcost   = upd ? total_reg : bcost_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        n_next = n_reg;
        m_next = m_reg;
        p_next = p_reg;
        q_next = q_reg;
        r_next = r_reg;
        s_next = s_reg;
        i_next = i_reg;
        lab_next = lab_reg;
        clr_next = clr_reg;
        v1_next = 1'b0;
        v2_next = v1_reg;
        v3_next = v2_reg;
        diff_next = (sa >= sb) ? VB'(sa - sb) : VB'(sb - sa);
        sq_next = (2*VB)'(diff_reg) * (2*VB)'(diff_reg);
        acc_next = v3_reg ? acc_reg + SW'(sq_reg) : acc_reg;
        x_next = x_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        step_next = step_reg;
        best_next = best_reg;
        bslot_next = bslot_reg;
        total_next = total_reg;
        bcost_next = bcost_reg;
        brec_next = brec_reg;
        seed = 1'b0;
        med_we = 1'b0;
        med_wdata = q_reg;
        cost_we = 1'b0;
        pm_we = 1'b0;
        lb_we = 1'b0;
        lb_waddr = r_reg;
        lb_wdata = gkm_pkg::LBL_W'(bslot_reg);
        rdrec_next = rdrec_reg;
        ov_next = ov_reg && res_stall;
        okind_next = okind_reg;
        oslot_next = oslot_reg;
        orec_next = orec_reg;
        olbl_next = olbl_reg;
        ocost_next = ocost_reg;
        olast_next = olast_reg;

        if (cfg_en)
        begin
            unique case (cfg_index)
                gkm_pkg::CFG_CLUSTERS:   k_next = gkm_pkg::K_W'(cfg_data);
                gkm_pkg::CFG_RECORDS:    n_next = cfg_data;
                gkm_pkg::CFG_ATTRIBUTES: m_next = gkm_pkg::M_W'(cfg_data);
                default: ;
            endcase
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                lb_we = 1'b1;
                lb_waddr = clr_reg;
                lb_wdata = '0;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == MAX_RECORDS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == gkm_pkg::CMD_LOAD)
                    begin
                        pm_we = (32'(record_index) < MAX_RECORDS)
                             && (32'(attribute_index) < MAX_ATTRIBUTES);
                    end
                    else if (command == gkm_pkg::CMD_RUN && !bad_cfg)
                    begin
                        seed = 1'b1;
                        p_next = '0;
                        q_next = '0;
                        lab_next = 1'b0;
                        state_next = S_QSTART;
                    end
                    else if (command == gkm_pkg::CMD_READ
                             && 32'(record_index) < MAX_RECORDS)
                    begin
                        rdrec_next = record_index;
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                        okind_next = gkm_pkg::KIND_ERROR;
                        oslot_next = '0;
                        orec_next = '0;
                        olbl_next = '0;
                        ocost_next = '0;
                        olast_next = 1'b1;
                    end
                end
            end
            S_RDWAIT:
            begin
                ov_next = 1'b1;
                okind_next = gkm_pkg::KIND_LABEL;
                oslot_next = '0;
                orec_next = rdrec_reg;
                olbl_next = lb_rdata;
                ocost_next = '0;
                olast_next = 1'b1;
                state_next = S_IDLE;
            end
            S_QSTART:
            begin
                med_we = 1'b1;
                med_wdata = q_reg;
                r_next = '0;
                total_next = '0;
                state_next = S_RSTART;
            end
            S_RSTART:
            begin
                s_next = '0;
                state_next = S_DSTART;
            end
            S_DSTART:
            begin
                i_next = '0;
                acc_next = '0;
                v2_next = 1'b0;
                v3_next = 1'b0;
                state_next = S_DIST;
            end
            S_DIST:
            begin
                if (32'(i_reg) < 32'(m_reg))
                begin
                    v1_next = 1'b1;
                    i_next = i_reg + 1'b1;
                end
                else if (!v1_reg && !v2_reg && !v3_reg)
                begin
                    x_next = (|(acc_reg >> SQW)) ? XW'({SQW{1'b1}})
                                                 : XW'(acc_reg[SQW-1:0]);
                    res_next = '0;
                    bit_next = BIT_INIT;
                    step_next = '0;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                if (x_reg >= sq_try)
                begin
                    x_next = x_reg - sq_try;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                step_next = step_reg + 1'b1;
                if (32'(step_reg) == NSTEP - 1)
                begin
                    state_next = S_NEAR;
                end
            end
            S_NEAR:
            begin
                if (s_reg == '0 || dist_val < best_reg)
                begin
                    best_next = dist_val;
                    bslot_next = s_reg;
                end
                if (32'(s_reg) + 1 == 32'(k_reg))
                begin
                    state_next = S_REND;
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                    state_next = S_DSTART;
                end
            end
            S_REND:
            begin
                if (lab_reg)
                begin
                    lb_we = 1'b1;
                end
                else
                begin
                    total_next = (tsum > {1'b0, gkm_pkg::COST_MAX})
                               ? gkm_pkg::COST_MAX : tsum[gkm_pkg::COST_W-1:0];
                end
                if (32'(r_reg) + 1 == 32'(n_reg))
                begin
                    if (lab_reg)
                    begin
                        p_next = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_QEND;
                    end
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                    state_next = S_RSTART;
                end
            end
            S_QEND:
            begin
                brec_next = nbrec;
                bcost_next = nbcost;
                if (32'(q_reg) + 1 == 32'(n_reg))
                begin
                    med_we = 1'b1;
                    med_wdata = nbrec;
                    cost_we = 1'b1;
                    if (32'(p_reg) + 1 == 32'(k_reg))
                    begin
                        lab_next = 1'b1;
                        r_next = '0;
                        state_next = S_RSTART;
                    end
                    else
                    begin
                        p_next = p_reg + 1'b1;
                        q_next = '0;
                        state_next = S_QSTART;
                    end
                end
                else
                begin
                    q_next = q_reg + 1'b1;
                    state_next = S_QSTART;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    okind_next = gkm_pkg::KIND_MEDOID;
                    oslot_next = gkm_pkg::SLOT_W'(p_reg);
                    orec_next = gkm_pkg::REC_W'(medoid_reg[p_reg]);
                    olbl_next = '0;
                    ocost_next = cost_reg[p_reg];
                    olast_next = (32'(p_reg) + 1 == 32'(k_reg));
                    p_next = p_reg + 1'b1;
                    if (32'(p_reg) + 1 == 32'(k_reg))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            k_reg <= gkm_pkg::K_W'(1);
            n_reg <= gkm_pkg::N_W'(1);
            m_reg <= gkm_pkg::M_W'(1);
            p_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
            s_reg <= '0;
            i_reg <= '0;
            lab_reg <= 1'b0;
            clr_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            step_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg <= k_next;
            n_reg <= n_next;
            m_reg <= m_next;
            p_reg <= p_next;
            q_reg <= q_next;
            r_reg <= r_next;
            s_reg <= s_next;
            i_reg <= i_next;
            lab_reg <= lab_next;
            clr_reg <= clr_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            step_reg <= step_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_reg <= sq_next;
        acc_reg <= acc_next;
        x_reg <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        best_reg <= best_next;
        bslot_reg <= bslot_next;
        total_reg <= total_next;
        bcost_reg <= bcost_next;
        brec_reg <= brec_next;
        rdrec_reg <= rdrec_next;
        okind_reg <= okind_next;
        oslot_reg <= oslot_next;
        orec_reg <= orec_next;
        olbl_reg <= olbl_next;
        ocost_reg <= ocost_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk)
    begin
        if (seed)
        begin
            for (int j = 0; j < MAX_CLUSTERS; j++)
            begin
                medoid_reg[j] <= RB'(j);
            end
        end
        else if (med_we)
        begin
            medoid_reg[p_reg] <= med_wdata;
        end
        if (cost_we)
        begin
            cost_reg[p_reg] <= nbcost;
        end
    end

    assign res_valid     = ov_reg;
    assign item_kind     = okind_reg;
    assign slot          = oslot_reg;
    assign chosen_record = orec_reg;
    assign cluster_label = olbl_reg;
    assign total_cost    = ocost_reg;
    assign last          = olast_reg;

endmodule

// File: rtl/gkm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gkm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: test/tb_greedy_k_medoids_clustering.sv
// Self-checking testbench for the greedy k-medoids engine: command stream and result checker.
module tb_greedy_k_medoids_clustering;

    localparam int NREC  = 256;
    localparam int NATT  = 8;
    localparam int NCLU  = 16;
    localparam longint LIMIT = 3000000;
    localparam gkm_pkg::cmd_t CMD_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [gkm_pkg::CMD_W-1:0]  cmd;
        logic [15:0]                val;
        logic [gkm_pkg::REC_W-1:0]  rec;
        logic [gkm_pkg::ATT_W-1:0]  att;
    } cmd_word_t;

    typedef struct packed {
        logic [gkm_pkg::KIND_W-1:0] kind;
        logic [gkm_pkg::SLOT_W-1:0] slt;
        logic [gkm_pkg::REC_W-1:0]  rec;
        logic [gkm_pkg::LBL_W-1:0]  lab;
        logic [gkm_pkg::COST_W-1:0] cost;
        logic                       lst;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_en;
    logic [gkm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [gkm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic cmd_valid;
    logic cmd_stall;
    logic [gkm_pkg::CMD_W-1:0] command;
    logic [15:0] value;
    logic [gkm_pkg::REC_W-1:0] record_index;
    logic [gkm_pkg::ATT_W-1:0] attribute_index;
    logic res_valid;
    logic res_stall;
    logic [gkm_pkg::KIND_W-1:0] item_kind;
    logic [gkm_pkg::SLOT_W-1:0] slot;
    logic [gkm_pkg::REC_W-1:0] chosen_record;
    logic [gkm_pkg::LBL_W-1:0] cluster_label;
    logic [gkm_pkg::COST_W-1:0] total_cost;
    logic last;

    greedy_k_medoids_clustering DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .command(command), .value(value),
        .record_index(record_index), .attribute_index(attribute_index),
        .res_valid(res_valid), .res_stall(res_stall), .item_kind(item_kind), .slot(slot),
        .chosen_record(chosen_record), .cluster_label(cluster_label),
        .total_cost(total_cost), .last(last)
    );

    // model state
    logic signed [15:0] points [NREC][NATT];
    bit                 loaded [NREC][NATT];
    int unsigned        medoids [NCLU];
    logic [3:0]         labels [NREC];
    int unsigned        k_reg;
    int unsigned        n_reg;
    int unsigned        m_reg;

    cmd_word_t pending_words [$];
    result_t   expected_results [$];
    int        fail_count;
    bit        long_hold_req;
    longint    cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned trial;
        res = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = res | (64'(1) << b);
            if (trial * trial <= x)
                res = trial;
        end
        return res;
    endfunction

    function automatic longint unsigned point_distance(int unsigned a, int unsigned b);
        longint unsigned sum;
        longint signed d;
        sum = 0;
        for (int i = 0; i < m_reg; i++)
        begin
            d = longint'(points[a][i]) - longint'(points[b][i]);
            if (d < 0)
                d = -d;
            sum += d * d;
        end
        return int_sqrt(sum);
    endfunction

    function automatic int unsigned nearest_medoid(int unsigned r, int unsigned k,
                                                   output int unsigned best_slot);
        longint unsigned best;
        longint unsigned d;
        best = 0;
        best_slot = 0;
        for (int s = 0; s < k; s++)
        begin
            d = point_distance(r, medoids[s]);
            if (s == 0 || d < best)
            begin
                best = d;
                best_slot = s;
            end
        end
        return (best > gkm_pkg::COST_MAX) ? 32'(gkm_pkg::COST_MAX) : 32'(best);
    endfunction

    function automatic result_t make_result(gkm_pkg::kind_t kind, int unsigned s,
                                            int unsigned r, int unsigned l,
                                            int unsigned c, bit lst);
        result_t x;
        x.kind = kind;
        x.slt  = gkm_pkg::SLOT_W'(s);
        x.rec  = gkm_pkg::REC_W'(r);
        x.lab  = gkm_pkg::LBL_W'(l);
        x.cost = gkm_pkg::COST_W'(c);
        x.lst  = lst;
        return x;
    endfunction

    function automatic void predict_medoid_run();
        int unsigned k;
        int unsigned n;
        int unsigned costs [NCLU];
        int unsigned best_cost;
        int unsigned best_rec;
        int unsigned total;
        int unsigned d;
        int unsigned s;
        k = k_reg;
        n = n_reg;
        if (k == 0 || k > NCLU || k > n || n == 0 || n > NREC || m_reg == 0 || m_reg > NATT)
        begin
            expected_results.push_back(make_result(gkm_pkg::KIND_ERROR, 0, 0, 0, 0, 1'b1));
            return;
        end
        for (int p = 0; p < k; p++)
            medoids[p] = p;
        for (int p = 0; p < k; p++)
        begin
            best_cost = 0;
            best_rec = 0;
            for (int q = 0; q < n; q++)
            begin
                medoids[p] = q;
                total = 0;
                for (int r = 0; r < n; r++)
                begin
                    d = nearest_medoid(r, k, s);
                    total = (total > gkm_pkg::COST_MAX - d) ? 32'(gkm_pkg::COST_MAX)
                                                             : total + d;
                end
                if (q == 0 || total < best_cost)
                begin
                    best_cost = total;
                    best_rec = q;
                end
            end
            medoids[p] = best_rec;
            costs[p] = best_cost;
        end
        for (int r = 0; r < n; r++)
        begin
            d = nearest_medoid(r, k, s);
            labels[r] = 4'(s);
        end
        for (int p = 0; p < k; p++)
            expected_results.push_back(make_result(gkm_pkg::KIND_MEDOID, p, medoids[p], 0,
                                                   costs[p], p + 1 == k));
    endfunction

    function automatic void predict_word(cmd_word_t w);
        case (w.cmd)
            gkm_pkg::CMD_LOAD: points[w.rec][w.att] = w.val;
            gkm_pkg::CMD_RUN:  predict_medoid_run();
            gkm_pkg::CMD_READ: expected_results.push_back(make_result(gkm_pkg::KIND_LABEL, 0,
                                                          w.rec, labels[w.rec], 0, 1'b1));
            default: expected_results.push_back(make_result(gkm_pkg::KIND_ERROR, 0, 0, 0, 0,
                                                            1'b1));
        endcase
    endfunction

    // driver
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        cmd_word_t w;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            command <= gkm_pkg::CMD_LOAD;
            value <= '0;
            record_index <= '0;
            attribute_index <= '0;
            burst_left <= 4;
            gap_left <= 0;
        end
        else if (!cmd_valid || !cmd_stall)
        begin
            if (cmd_valid)
                predict_word('{command, value, record_index, attribute_index});
            if (gap_left > 0 || pending_words.size() == 0)
            begin
                cmd_valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                w = pending_words.pop_front();
                cmd_valid <= 1'b1;
                command <= w.cmd;
                value <= w.val;
                record_index <= w.rec;
                attribute_index <= w.att;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor
    int stall_mode;
    int mode_left;
    int hold_left;

    task automatic check_field(string name, longint e, longint a);
        if (e != a)
        begin
            $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, name, e, a);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_mode <= 0;
            mode_left <= 64;
            hold_left <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected word, actual kind %0d record %0d", $time,
                             item_kind, chosen_record);
                    fail_count++;
                end
                else
                begin
                    e = expected_results.pop_front();
                    check_field("item_kind", e.kind, item_kind);
                    check_field("slot", e.slt, slot);
                    check_field("chosen_record", e.rec, chosen_record);
                    check_field("cluster_label", e.lab, cluster_label);
                    check_field("total_cost", e.cost, total_cost);
                    check_field("last", e.lst, last);
                end
            end
            if (long_hold_req && hold_left == 0)
            begin
                long_hold_req <= 1'b0;
                hold_left <= 300;
                res_stall <= 1'b1;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                res_stall <= (hold_left > 1);
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(16, 96);
                end
                else
                    mode_left <= mode_left - 1;
                case (stall_mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 9) < 3);
                    default: res_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(gkm_pkg::cfg_idx_t idx, int unsigned data);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= gkm_pkg::CFG_DATA_W'(data);
        @(posedge clk);
        cfg_en <= 1'b0;
        case (idx)
            gkm_pkg::CFG_CLUSTERS: k_reg = data & 31;
            gkm_pkg::CFG_RECORDS:  n_reg = data & 511;
            default:               m_reg = data & 15;
        endcase
    endtask

    task automatic set_config(int unsigned k, int unsigned n, int unsigned m);
        write_reg(gkm_pkg::CFG_CLUSTERS, k);
        write_reg(gkm_pkg::CFG_RECORDS, n);
        write_reg(gkm_pkg::CFG_ATTRIBUTES, m);
    endtask

    task automatic wait_idle();
        while (pending_words.size() != 0 || cmd_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic void queue_word(gkm_pkg::cmd_t c, logic [15:0] v, int r, int a);
        cmd_word_t w;
        w = '{c, v, r[7:0], a[2:0]};
        if (c == gkm_pkg::CMD_LOAD)
            loaded[r][a] = 1'b1;
        pending_words.push_back(w);
    endfunction

    // every point a run will touch must hold written data
    function automatic void queue_run(int unsigned n, int unsigned m);
        for (int r = 0; r < n && r < NREC; r++)
            for (int a = 0; a < m && a < NATT; a++)
                if (!loaded[r][a])
                    queue_word(gkm_pkg::CMD_LOAD, 16'($urandom), r, a);
        queue_word(gkm_pkg::CMD_RUN, 16'($urandom), $urandom_range(0, 255),
                   $urandom_range(0, 7));
    endfunction

    initial
    begin
        int unsigned k;
        int unsigned n;
        int unsigned m;
        int sel;
        fail_count = 0;
        long_hold_req = 1'b0;
        cycle_count = 0;
        cfg_en = 1'b0;
        cfg_index = gkm_pkg::CFG_CLUSTERS;
        cfg_data = '0;
        k_reg = 1;
        n_reg = 1;
        m_reg = 1;
        for (int i = 0; i < NREC; i++)
        begin
            labels[i] = '0;
            for (int j = 0; j < NATT; j++)
            begin
                points[i][j] = '0;
                loaded[i][j] = 1'b0;
            end
        end
        for (int i = 0; i < NCLU; i++)
            medoids[i] = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (300) @(posedge clk);

        // directed
        set_config(1, 1, 1);
        queue_word(gkm_pkg::CMD_LOAD, 16'h8000, 0, 0);
        queue_word(gkm_pkg::CMD_LOAD, 16'h7FFF, 255, 7);
        queue_word(gkm_pkg::CMD_READ, 16'hFFFF, 0, 7);
        queue_word(gkm_pkg::CMD_READ, 16'h0000, 255, 0);
        queue_word(CMD_UNKNOWN, 16'hFFFF, 255, 7);
        queue_run(1, 1);
        wait_idle();

        set_config(3, 5, 8);
        queue_word(gkm_pkg::CMD_LOAD, 16'h7FFF, 1, 0);
        queue_word(gkm_pkg::CMD_LOAD, 16'h8000, 2, 0);
        queue_word(gkm_pkg::CMD_LOAD, 16'h7FFF, 3, 7);
        queue_word(gkm_pkg::CMD_LOAD, 16'h8000, 4, 7);
        queue_run(5, 8);
        for (int r = 0; r < 5; r++)
            queue_word(gkm_pkg::CMD_READ, '0, r, 0);
        wait_idle();

        // bad settings, each run gives one error word
        set_config(0, 5, 2);
        queue_run(0, 0);
        wait_idle();
        set_config(17, 256, 2);
        queue_run(0, 0);
        wait_idle();
        set_config(16, 5, 2);
        queue_run(0, 0);
        wait_idle();
        set_config(1, 0, 2);
        queue_run(0, 0);
        wait_idle();
        set_config(1, 511, 2);
        queue_run(0, 0);
        wait_idle();
        set_config(2, 4, 0);
        queue_run(0, 0);
        wait_idle();
        set_config(2, 4, 15);
        queue_run(0, 0);
        wait_idle();

        // random phases
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 4)
            begin
                k = 4;
                n = 8;
                m = 8;
            end
            else
            begin
                k = $urandom_range(1, 3);
                n = $urandom_range(k, 6);
                m = $urandom_range(1, 8);
            end
            set_config(k, n, m);
            if (ph == 3)
                long_hold_req = 1'b1;
            for (int i = 0; i < 6; i++)
            begin
                sel = $urandom_range(0, 19);
                if (ph == 3 || sel < 6)
                    queue_word(gkm_pkg::CMD_READ, 16'($urandom), $urandom_range(0, 255),
                               $urandom_range(0, 7));
                else if (sel < 17)
                    queue_word(gkm_pkg::CMD_LOAD, 16'($urandom), $urandom_range(0, n - 1),
                               $urandom_range(0, m - 1));
                else if (sel < 19)
                    queue_word(gkm_pkg::CMD_LOAD, 16'($urandom), $urandom_range(0, 255),
                               $urandom_range(0, 7));
                else
                    queue_word(CMD_UNKNOWN, 16'($urandom), $urandom_range(0, 255),
                               $urandom_range(0, 7));
                if (i == 3)
                    queue_run(n, m);
            end
            for (int r = 0; r < n; r++)
                queue_word(gkm_pkg::CMD_READ, 16'($urandom), r, $urandom_range(0, 7));
            wait_idle();
        end

        if (fail_count == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
